FILE: hw/rtl/rau_pkg.sv
`timescale 1ns / 1ps

package rau_pkg;

    // Range limit of the reduced result: numerator and denominator are held to WIDTH bits.
    localparam int WIDTH = 32;

    localparam int OP_BITS  = 32;
    localparam int WIDE     = 2 * OP_BITS;
    localparam int CNT_BITS = $clog2(WIDE);

    localparam int MODE_BITS   = 3;
    localparam int NUM_BITS    = 32;
    localparam int DEN_BITS    = 31;
    localparam int STATUS_BITS = 2;

    localparam int IN_FIELD_BITS  = MODE_BITS + 4 * OP_BITS;
    localparam int IN_BITS        = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = NUM_BITS + DEN_BITS + STATUS_BITS;
    localparam int OUT_BITS       = ((OUT_FIELD_BITS + 7) / 8) * 8;

    localparam logic [MODE_BITS-1:0] MODE_NORM  = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_ADD   = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_SUB   = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_MUL   = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_DIV   = 3'd4;
    localparam logic [MODE_BITS-1:0] MODE_NEG   = 3'd5;
    localparam logic [MODE_BITS-1:0] MODE_RECIP = 3'd6;

    localparam logic [STATUS_BITS-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_DIVZ = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_OVF  = 2'd2;

    localparam logic [WIDE-1:0] LIM = (WIDE'(1) << (WIDTH - 1)) - WIDE'(1);

endpackage

FILE: hw/rtl/rational_arithmetic_unit.sv
`timescale 1ns / 1ps

// Rational arithmetic unit. Each input transfer carries an operation (normalise, add, subtract,
// multiply, divide, negate, reciprocal) and two fractions of 32-bit signed numerator and
// denominator. The result is reduced to lowest terms with a positive denominator and returned
// with a status: ok, division by zero, or range overflow (numerator and denominator are then
// zero). One item is worked on at a time and s_tready is low while it is in flight. A binary
// operation first forms its products on the shared 32x32 multiplier, then the sum.
// A binary gcd then runs on one 64-bit compare-subtract unit, with one shift or one subtraction
// per cycle. Two restoring divisions on that same datapath then divide numerator and
// denominator by the gcd. A zero result skips the gcd and the divisions. Items that fail the
// zero checks go straight to the output step. A finished result is held in the output
// register, so the next item is accepted while it waits for m_tready.
module rational_arithmetic_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // From bit 0: mode[3], a_num[32], a_den[32], b_num[32], b_den[32], zero padding.
    input  logic [rau_pkg::IN_BITS-1:0]  s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // From bit 0: res_num[32], res_den[31], status[2], zero padding.
    output logic [rau_pkg::OUT_BITS-1:0] m_tdata
);
    import rau_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL_P, S_MUL_Q, S_MUL_D, S_SUM, S_PREP,
        S_GCD_EVEN, S_GCD, S_DIV_N, S_DIV_D, S_CHECK, S_OUT
    } state_t;

    state_t                 state_reg, state_next;
    logic [MODE_BITS-1:0]   mode_reg, mode_next;
    logic [OP_BITS-1:0]     na_reg, na_next, da_reg, da_next, nb_reg, nb_next, db_reg, db_next;
    logic                   sa_reg, sa_next, sb_reg, sb_next, s_reg, s_next;
    logic [WIDE-1:0]        p_reg, p_next, q_reg, q_next, n_reg, n_next, d_reg, d_next;
    logic [WIDE-1:0]        u_reg, u_next, v_reg, v_next, g_reg, g_next;
    logic [WIDE:0]          rem_reg, rem_next;
    logic [CNT_BITS-1:0]    k_reg, k_next, cnt_reg, cnt_next;
    logic [NUM_BITS-1:0]    rnum_reg, rnum_next;
    logic [DEN_BITS-1:0]    rden_reg, rden_next;
    logic [STATUS_BITS-1:0] rst_reg, rst_next;
    logic                   mval_reg, mval_next;

    // Input fields and their sign / magnitude split.
    logic [MODE_BITS-1:0] in_mode;
    logic [OP_BITS-1:0]   in_an, in_ad, in_bn, in_bd;
    logic [OP_BITS-1:0]   mag_an, mag_ad, mag_bn, mag_bd;
    logic                 binary_op;

    // Shared multiplier.
    logic [OP_BITS-1:0] mul_x, mul_y;
    logic [WIDE-1:0]    mul_p;

    // Shared compare-subtract unit.
    logic [WIDE:0]   cs_a, cs_b, cs_diff;
    logic            cs_ge;
    logic [WIDE:0]   rem_sh;
    logic            sq;

    assign in_mode = s_tdata[MODE_BITS-1:0];
    assign in_an   = s_tdata[MODE_BITS +: OP_BITS];
    assign in_ad   = s_tdata[MODE_BITS + OP_BITS +: OP_BITS];
    assign in_bn   = s_tdata[MODE_BITS + 2*OP_BITS +: OP_BITS];
    assign in_bd   = s_tdata[MODE_BITS + 3*OP_BITS +: OP_BITS];

    assign mag_an = in_an[OP_BITS-1] ? (~in_an + OP_BITS'(1)) : in_an;
    assign mag_ad = in_ad[OP_BITS-1] ? (~in_ad + OP_BITS'(1)) : in_ad;
    assign mag_bn = in_bn[OP_BITS-1] ? (~in_bn + OP_BITS'(1)) : in_bn;
    assign mag_bd = in_bd[OP_BITS-1] ? (~in_bd + OP_BITS'(1)) : in_bd;

    assign binary_op = (in_mode == MODE_ADD) || (in_mode == MODE_SUB) ||
                       (in_mode == MODE_MUL) || (in_mode == MODE_DIV);

    // Multiplier operands follow the step of the sequence and the operation.
    always_comb begin
        mul_x = da_reg;
        mul_y = db_reg;
        case (state_reg)
            S_MUL_P: begin
                mul_x = na_reg;
                mul_y = (mode_reg == MODE_MUL) ? nb_reg : db_reg;
            end
            S_MUL_Q: begin
                mul_x = nb_reg;
                mul_y = da_reg;
            end
            default: begin
                mul_x = da_reg;
                mul_y = (mode_reg == MODE_DIV) ? nb_reg : db_reg;
            end
        endcase
    end

    assign mul_p = WIDE'(mul_x) * WIDE'(mul_y);

    // The sign of the second term of an add or subtract, flipped for a subtract.
    assign sq = (mode_reg == MODE_SUB) ? !sb_reg : sb_reg;

    // One compare-subtract unit serves the sum, the gcd and the divisions.
    assign rem_sh = {rem_reg[WIDE-1:0], u_reg[WIDE-1]};
    always_comb begin
        cs_a = {1'b0, p_reg};
        cs_b = {1'b0, q_reg};
        case (state_reg)
            S_GCD: begin
                cs_a = {1'b0, u_reg};
                cs_b = {1'b0, v_reg};
            end
            S_DIV_N, S_DIV_D: begin
                cs_a = rem_sh;
                cs_b = {1'b0, g_reg};
            end
            default: begin
                cs_a = {1'b0, p_reg};
                cs_b = {1'b0, q_reg};
            end
        endcase
    end

    assign cs_diff = cs_a - cs_b;
    assign cs_ge   = !cs_diff[WIDE];

    always_comb begin
        state_next = state_reg;
        mode_next  = mode_reg;
        na_next    = na_reg;
        da_next    = da_reg;
        nb_next    = nb_reg;
        db_next    = db_reg;
        sa_next    = sa_reg;
        sb_next    = sb_reg;
        s_next     = s_reg;
        p_next     = p_reg;
        q_next     = q_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        u_next     = u_reg;
        v_next     = v_reg;
        g_next     = g_reg;
        rem_next   = rem_reg;
        k_next     = k_reg;
        cnt_next   = cnt_reg;
        rnum_next  = rnum_reg;
        rden_next  = rden_reg;
        rst_next   = rst_reg;
        mval_next  = mval_reg && !m_tready;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    mode_next = in_mode;
                    na_next   = mag_an;
                    da_next   = mag_ad;
                    nb_next   = mag_bn;
                    db_next   = mag_bd;
                    sa_next   = in_an[OP_BITS-1] ^ in_ad[OP_BITS-1];
                    sb_next   = in_bn[OP_BITS-1] ^ in_bd[OP_BITS-1];
                    if ((mag_ad == '0) || (binary_op && (mag_bd == '0)) ||
                        ((in_mode == MODE_DIV) && (mag_bn == '0)) ||
                        ((in_mode == MODE_RECIP) && (mag_an == '0))) begin
                        rnum_next  = '0;
                        rden_next  = '0;
                        rst_next   = ST_DIVZ;
                        state_next = S_OUT;
                    end else if (binary_op) begin
                        state_next = S_MUL_P;
                    end else begin
                        // Unary operations skip the multiplier.
                        case (in_mode)
                            MODE_NEG: begin
                                n_next = WIDE'(mag_an);
                                d_next = WIDE'(mag_ad);
                                s_next = !(in_an[OP_BITS-1] ^ in_ad[OP_BITS-1]);
                            end
                            MODE_RECIP: begin
                                n_next = WIDE'(mag_ad);
                                d_next = WIDE'(mag_an);
                                s_next = in_an[OP_BITS-1] ^ in_ad[OP_BITS-1];
                            end
                            default: begin
                                n_next = WIDE'(mag_an);
                                d_next = WIDE'(mag_ad);
                                s_next = in_an[OP_BITS-1] ^ in_ad[OP_BITS-1];
                            end
                        endcase
                        state_next = S_PREP;
                    end
                end
            end
            S_MUL_P: begin
                p_next     = mul_p;
                state_next = ((mode_reg == MODE_ADD) || (mode_reg == MODE_SUB)) ?
                             S_MUL_Q : S_MUL_D;
            end
            S_MUL_Q: begin
                q_next     = mul_p;
                state_next = S_MUL_D;
            end
            S_MUL_D: begin
                d_next     = mul_p;
                state_next = S_SUM;
            end
            S_SUM: begin
                case (mode_reg)
                    MODE_ADD, MODE_SUB: begin
                        if (sa_reg == sq) begin
                            n_next = p_reg + q_reg;
                            s_next = sa_reg;
                        end else if (cs_ge) begin
                            n_next = cs_diff[WIDE-1:0];
                            s_next = sa_reg;
                        end else begin
                            n_next = q_reg - p_reg;
                            s_next = sq;
                        end
                    end
                    default: begin
                        n_next = p_reg;
                        s_next = sa_reg ^ sb_reg;
                    end
                endcase
                state_next = S_PREP;
            end
            S_PREP: begin
                if (n_reg == '0) begin
                    // A zero value is reported as 0/1 with no gcd pass.
                    d_next     = WIDE'(1);
                    s_next     = 1'b0;
                    state_next = S_CHECK;
                end else begin
                    u_next     = n_reg;
                    v_next     = d_reg;
                    k_next     = '0;
                    state_next = S_GCD_EVEN;
                end
            end
            S_GCD_EVEN: begin
                // Strip the powers of two common to both operands.
                if (!u_reg[0] && !v_reg[0]) begin
                    u_next = u_reg >> 1;
                    v_next = v_reg >> 1;
                    k_next = k_reg + CNT_BITS'(1);
                end else begin
                    state_next = S_GCD;
                end
            end
            S_GCD: begin
                if ((u_reg == '0) || (v_reg == '0)) begin
                    g_next     = (u_reg | v_reg) << k_reg;
                    u_next     = n_reg;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = S_DIV_N;
                end else if (!u_reg[0]) begin
                    u_next = u_reg >> 1;
                end else if (!v_reg[0]) begin
                    v_next = v_reg >> 1;
                end else if (cs_ge) begin
                    u_next = cs_diff[WIDE-1:0];
                end else begin
                    v_next = v_reg - u_reg;
                end
            end
            S_DIV_N, S_DIV_D: begin
                // Restoring division: dividend shifts out of u, quotient shifts in.
                rem_next = cs_ge ? cs_diff : rem_sh;
                u_next   = {u_reg[WIDE-2:0], cs_ge};
                cnt_next = cnt_reg + CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(WIDE - 1)) begin
                    if (state_reg == S_DIV_N) begin
                        n_next     = {u_reg[WIDE-2:0], cs_ge};
                        u_next     = d_reg;
                        rem_next   = '0;
                        state_next = S_DIV_D;
                    end else begin
                        d_next     = {u_reg[WIDE-2:0], cs_ge};
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if ((d_reg > LIM) || (n_reg > (s_reg ? LIM + WIDE'(1) : LIM))) begin
                    rnum_next = '0;
                    rden_next = '0;
                    rst_next  = ST_OVF;
                end else begin
                    rnum_next = s_reg ? (~n_reg[NUM_BITS-1:0] + NUM_BITS'(1))
                                      : n_reg[NUM_BITS-1:0];
                    rden_next = d_reg[DEN_BITS-1:0];
                    rst_next  = ST_OK;
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                // Load the output register once the previous result has gone.
                if (!mval_reg || m_tready) begin
                    mval_next  = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    rnum_next = rnum_reg;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Result fields are copied into the output register only on the load in S_OUT.
    logic [NUM_BITS-1:0]    onum_reg;
    logic [DEN_BITS-1:0]    oden_reg;
    logic [STATUS_BITS-1:0] ost_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            mval_reg  <= mval_next;
        end
        mode_reg <= mode_next;
        na_reg   <= na_next;
        da_reg   <= da_next;
        nb_reg   <= nb_next;
        db_reg   <= db_next;
        sa_reg   <= sa_next;
        sb_reg   <= sb_next;
        s_reg    <= s_next;
        p_reg    <= p_next;
        q_reg    <= q_next;
        n_reg    <= n_next;
        d_reg    <= d_next;
        u_reg    <= u_next;
        v_reg    <= v_next;
        g_reg    <= g_next;
        rem_reg  <= rem_next;
        k_reg    <= k_next;
        cnt_reg  <= cnt_next;
        rnum_reg <= rnum_next;
        rden_reg <= rden_next;
        rst_reg  <= rst_next;
        if ((state_reg == S_OUT) && (!mval_reg || m_tready)) begin
            onum_reg <= rnum_reg;
            oden_reg <= rden_reg;
            ost_reg  <= rst_reg;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mval_reg;
    assign m_tdata  = {(OUT_BITS - OUT_FIELD_BITS)'(0), ost_reg, oden_reg, onum_reg};

endmodule

FILE: sim/rau_checker.sv
`timescale 1ns / 1ps

// Watches both streams, predicts each result and compares it with what the unit returns.
module rau_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [rau_pkg::IN_BITS-1:0]  s_tdata,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [rau_pkg::OUT_BITS-1:0] m_tdata,
    output int                           errors,
    output int                           pending
);
    import rau_pkg::*;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [DEN_BITS-1:0]    den;
        logic [NUM_BITS-1:0]    num;
    } fraction_t;

    localparam int DEPTH = 64;

    fraction_t expected_fractions[DEPTH];
    int        wr_count = 0;
    int        rd_count = 0;

    function automatic logic [63:0] magnitude(input logic [31:0] v);
        logic [31:0] m;
        m = v[31] ? (~v + 32'd1) : v;
        return {32'd0, m};
    endfunction

    function automatic logic [63:0] gcd64(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic fraction_t predict_fraction(input logic [IN_BITS-1:0] d);
        logic [2:0]  mode;
        logic [31:0] an, ad, bn, bd;
        logic [63:0] na, da, nb, db, n, dd, p, q, g, lim;
        logic        sa, sb, sq, s, binary;
        fraction_t   r;
        mode = d[2:0];
        an = d[34:3];
        ad = d[66:35];
        bn = d[98:67];
        bd = d[130:99];
        binary = mode >= MODE_ADD && mode <= MODE_DIV;
        sa = an[31] != ad[31];
        sb = bn[31] != bd[31];
        na = magnitude(an);
        da = magnitude(ad);
        nb = magnitude(bn);
        db = magnitude(bd);
        r = '0;
        r.status = ST_DIVZ;
        if (da == 0 || (binary && db == 0)) return r;
        if ((mode == MODE_DIV && nb == 0) || (mode == MODE_RECIP && na == 0)) return r;
        case (mode)
            MODE_ADD, MODE_SUB: begin
                p = na * db;
                q = nb * da;
                sq = (mode == MODE_SUB) ? !sb : sb;
                if (sa == sq) begin
                    n = p + q;
                    s = sa;
                end else if (p >= q) begin
                    n = p - q;
                    s = sa;
                end else begin
                    n = q - p;
                    s = sq;
                end
                dd = da * db;
            end
            MODE_MUL: begin
                n = na * nb;
                dd = da * db;
                s = sa != sb;
            end
            MODE_DIV: begin
                n = na * db;
                dd = da * nb;
                s = sa != sb;
            end
            MODE_NEG: begin
                n = na;
                dd = da;
                s = !sa;
            end
            MODE_RECIP: begin
                n = da;
                dd = na;
                s = sa;
            end
            default: begin
                n = na;
                dd = da;
                s = sa;
            end
        endcase
        if (n == 0) begin
            s = 1'b0;
            dd = 1;
        end
        g = gcd64(n, dd);
        n = n / g;
        dd = dd / g;
        lim = LIM;
        if (dd > lim || n > (s ? lim + 1 : lim)) begin
            r.status = ST_OVF;
            return r;
        end
        r.num = s ? 32'(-n) : 32'(n);
        r.den = 31'(dd);
        r.status = ST_OK;
        return r;
    endfunction

    fraction_t got, want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            errors <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_fractions[wr_count % DEPTH] <= predict_fraction(s_tdata);
                wr_count <= wr_count + 1;
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[OUT_FIELD_BITS-1:0];
                if (rd_count == wr_count) begin
                    errors <= errors + 1;
                    $display("%0t: unexpected result, actual %h", $time, got);
                end else begin
                    want = expected_fractions[rd_count % DEPTH];
                    rd_count <= rd_count + 1;
                    if (got.num !== want.num || got.den !== want.den
                            || got.status !== want.status) begin
                        errors <= errors + 1;
                        $display({"%0t: mismatch, expected num %0d den %0d st %0d,",
                                  " actual num %0d den %0d st %0d"},
                                 $time, $signed(want.num), want.den, want.status,
                                 $signed(got.num), got.den, got.status);
                    end
                end
            end
        end
    end

    assign pending = wr_count - rd_count;
endmodule

FILE: sim/rational_arithmetic_unit_tb.sv
`timescale 1ns / 1ps

module rational_arithmetic_unit_tb;
    import rau_pkg::*;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [IN_BITS-1:0]  s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_BITS-1:0] m_tdata;
    int                  errors, pending;
    int                  idle_cycles = 0;
    bit                  calm = 1'b0;
    bit                  hold_long = 1'b0;

    localparam int WATCHDOG = 20000;

    always #1 aclk = ~aclk;

    rational_arithmetic_unit uut (.*);

    rau_checker checker_i (.*);

    // Watchdog counts cycles with no transfer on either side.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver: random stall bursts, plus one long hold-off.
    initial begin
        int n;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_long) begin
                m_tready <= 1'b0;
                repeat (3000) @(posedge aclk);
                hold_long = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                n = $urandom_range(1, 11);
                repeat (n) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'($urandom_range(0, 20)) - 32'd10;
            1: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0, 16'($urandom)};
            2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            3: return 32'($urandom_range(0, 4000)) - 32'd2000;
            default: return $urandom;
        endcase
    endfunction

    // s_tvalid stays high after a transfer; the next call either offers the next item or idles.
    task automatic send_item(input logic [2:0] mode, input logic [31:0] an, input logic [31:0] ad,
                             input logic [31:0] bn, input logic [31:0] bd);
        int n;
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            n = $urandom_range(1, 11);
            repeat (n) @(posedge aclk);
        end
        s_tdata <= IN_BITS'({bd, bn, ad, an, mode});
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    initial begin
        logic [2:0] m;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // Directed: every operation, zero denominators and divisors, extremes, mode seven.
        send_item(MODE_NORM, 32'd6, 32'hFFFF_FFFC, 0, 0);
        send_item(MODE_NORM, 32'd5, 32'd0, 0, 0);
        send_item(MODE_NORM, 32'd0, 32'hFFFF_FFF9, 0, 0);
        send_item(MODE_NORM, 32'h8000_0000, 32'd1, 0, 0);
        send_item(MODE_NORM, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0);
        send_item(MODE_NORM, 32'd1, 32'h8000_0000, 0, 0);
        send_item(MODE_NORM, 32'h8000_0000, 32'h8000_0000, 0, 0);
        send_item(MODE_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
        send_item(MODE_ADD, 32'h7FFF_FFFF, 32'd1, 32'd1, 32'd1);
        send_item(MODE_ADD, 32'd1, 32'd2, 32'd1, 32'd0);
        send_item(MODE_SUB, 32'd1, 32'd3, 32'd1, 32'd2);
        send_item(MODE_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(MODE_SUB, 32'd3, 32'd4, 32'd3, 32'd4);
        send_item(MODE_MUL, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(MODE_MUL, 32'd2, 32'd3, 32'hFFFF_FFFD, 32'd4);
        send_item(MODE_DIV, 32'd2, 32'd3, 32'd0, 32'd5);
        send_item(MODE_DIV, 32'd2, 32'd3, 32'hFFFF_FFFC, 32'd9);
        send_item(MODE_NEG, 32'h8000_0000, 32'd1, 0, 0);
        send_item(MODE_NEG, 32'd3, 32'hFFFF_FFFA, 0, 0);
        send_item(MODE_RECIP, 32'd0, 32'd5, 0, 0);
        send_item(MODE_RECIP, 32'hFFFF_FFFE, 32'h8000_0000, 0, 0);
        send_item(3'd7, 32'd10, 32'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // Random items; the receiver holds off once to fill the unit.
        for (int i = 0; i < 1300; i++) begin
            if (i == 300) hold_long = 1'b1;
            if (i == 1150) calm = 1'b1;
            m = 3'($urandom_range(0, 7));
            send_item(m, rand_value(), rand_value(), rand_value(), rand_value());
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (pending == 0);
        repeat (400) @(posedge aclk);
        if (errors == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

FILE: filelist.f
hw/rtl/rau_pkg.sv
hw/rtl/rational_arithmetic_unit.sv
sim/rau_checker.sv
sim/rational_arithmetic_unit_tb.sv
